FILE: design/sat_pkg.sv
package sat_pkg;

    // Queue geometry and field widths.
    localparam int QUEUE_DEPTH  = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int DL_W         = 32;
    localparam int TAG_W        = 16;
    localparam int DELAY_W      = 16;
    localparam int KIND_W       = 2;
    localparam int DRAIN_CNT_W  = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;

    // Input item selector.
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

    // One stored alarm.
    typedef struct packed {
        logic             valid;
        logic [DL_W-1:0]  deadline;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

FILE: design/sat_cell.sv
module sat_cell
    import sat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [DL_W-1:0]  i_new_deadline,
    input  logic [TAG_W-1:0] i_new_tag,
    input  t_entry           i_prev,
    input  logic             i_prev_keep,
    input  t_entry           i_next,
    output t_entry           o_entry,
    output logic             o_keep
);

    logic             r_valid;
    logic [DL_W-1:0]  r_deadline;
    logic [TAG_W-1:0] r_tag;
    logic             n_valid;
    logic [DL_W-1:0]  n_deadline;
    logic [TAG_W-1:0] n_tag;

    // A cell keeps its alarm on insert when that alarm is due no later than
    // the new one, which keeps equal deadlines in arrival order.
    assign o_keep  = r_valid && (r_deadline <= i_new_deadline);
    assign o_entry = '{valid: r_valid, deadline: r_deadline, tag: r_tag};

    always_comb begin
        n_valid    = r_valid;
        n_deadline = r_deadline;
        n_tag      = r_tag;
        if (i_ctrl.insert) begin
            if (o_keep) begin
                n_valid = r_valid;
            end else if (i_prev_keep) begin
                n_valid    = 1'b1;
                n_deadline = i_new_deadline;
                n_tag      = i_new_tag;
            end else begin
                n_valid    = i_prev.valid;
                n_deadline = i_prev.deadline;
                n_tag      = i_prev.tag;
            end
        end else if (i_ctrl.shift) begin
            n_valid    = i_next.valid;
            n_deadline = i_next.deadline;
            n_tag      = i_next.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_deadline <= n_deadline;
        r_tag      <= n_tag;
    end

endmodule

FILE: design/sorted_alarm_timer_queue.sv
// An insert is registered at its input transfer, and its result enters the output register
// from the insert state once that register is free. A tick advances the time, then sends
// due alarms from the head cell, one per cycle while the output register can take them;
// no new item is taken until the current one ends. The head cell feeding one output register
// sets the drain rate. Reset (synchronous, active low) clears the time counter, every
// cell's valid bit, the control state and the output valid.
module sorted_alarm_timer_queue
    import sat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] delay_seconds, [31:16] tag
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] alarm_tag, [47:16] alarm_deadline
    output logic [1:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast    // last
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_INSERT = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Current time in seconds.
    logic [DL_W-1:0] r_now, n_now;

    // The pending insert, registered at its transfer.
    logic [DL_W-1:0]  r_new_deadline, n_new_deadline;
    logic [TAG_W-1:0] r_new_tag, n_new_tag;

    // Number of alarms already sent during the current tick.
    logic [DRAIN_CNT_W-1:0] r_drain_cnt, n_drain_cnt;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;
    logic [DL_W-1:0]   r_out_deadline, n_out_deadline;
    logic              r_out_last, n_out_last;

    // Cell chain wiring.
    t_cell_ctrl             w_ctrl;
    t_entry                 w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_valid;

    logic w_in_xfer;
    logic w_out_free;
    logic w_full;
    logic w_head_due;
    logic w_next_due;
    logic w_drain_last;

    // The input side is open whenever no item is in progress; a result that
    // still waits in the output register does not hold it back.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // The output register can take a new result when it is empty or its
    // current result transfers in this cycle.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Valid cells always form a prefix, so the tail cell tells whether the
    // queue is full.
    assign w_full = w_entry[QUEUE_DEPTH-1].valid;

    // Expiry looks at the head cell and the one behind it, which becomes the
    // head after the shift; the tick ends when that one is not due or when
    // the per-tick limit is reached.
    assign w_head_due   = w_entry[0].valid && (w_entry[0].deadline <= r_now);
    assign w_next_due   = w_entry[1].valid && (w_entry[1].deadline <= r_now);
    assign w_drain_last = !w_next_due ||
                          (r_drain_cnt == DRAIN_CNT_W'(RESULT_LIMIT - 1));

    assign w_ctrl.insert = (r_state == S_INSERT) && w_out_free && !w_full;
    assign w_ctrl.shift  = (r_state == S_DRAIN) && w_head_due && w_out_free;

    // Each cell hands its alarm to the next one on insert and to the
    // previous one on expiry. The head sees a neighbor that always keeps,
    // and the tail sees an empty neighbor behind it.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_keep;

            if (gi == 0) begin : g_head
                assign w_prev      = '0;
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev      = w_entry[gi-1];
                assign w_prev_keep = w_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_entry[gi+1];
            end

            sat_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctrl         (w_ctrl),
                .i_new_deadline (r_new_deadline),
                .i_new_tag      (r_new_tag),
                .i_prev         (w_prev),
                .i_prev_keep    (w_prev_keep),
                .i_next         (w_next),
                .o_entry        (w_entry[gi]),
                .o_keep         (w_keep[gi])
            );

            assign w_valid[gi] = w_entry[gi].valid;
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_now          = r_now;
        n_new_deadline = r_new_deadline;
        n_new_tag      = r_new_tag;
        n_drain_cnt    = r_drain_cnt;
        n_out_valid    = r_out_valid;
        n_out_kind     = r_out_kind;
        n_out_tag      = r_out_tag;
        n_out_deadline = r_out_deadline;
        n_out_last     = r_out_last;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_s_axis_tuser == MODE_INSERT) begin
                        // The deadline wraps modulo 2^32 like the time counter.
                        n_new_deadline = r_now + DL_W'(i_s_axis_tdata[DELAY_W-1:0]);
                        n_new_tag      = i_s_axis_tdata[DELAY_W +: TAG_W];
                        n_state        = S_INSERT;
                    end else begin
                        n_now       = r_now + DL_W'(1);
                        n_drain_cnt = '0;
                        n_state     = S_DRAIN;
                    end
                end
            end
            S_INSERT: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_kind     = w_full ? KIND_REJECTED : KIND_ACCEPTED;
                    n_out_tag      = r_new_tag;
                    n_out_deadline = r_new_deadline;
                    n_out_last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (!w_head_due) begin
                    // Nothing due on this tick: no result at all.
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_kind     = KIND_EXPIRED;
                    n_out_tag      = w_entry[0].tag;
                    n_out_deadline = w_entry[0].deadline;
                    n_out_last     = w_drain_last;
                    n_drain_cnt    = r_drain_cnt + DRAIN_CNT_W'(1);
                    if (w_drain_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_drain_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_drain_cnt <= n_drain_cnt;
            r_out_valid <= n_out_valid;
        end
        r_new_deadline <= n_new_deadline;
        r_new_tag      <= n_new_tag;
        r_out_kind     <= n_out_kind;
        r_out_tag      <= n_out_tag;
        r_out_deadline <= n_out_deadline;
        r_out_last     <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_deadline, r_out_tag};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // The valid cells must always be a contiguous run starting at the head.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + QUEUE_DEPTH'(1)) & w_valid) == '0)
        else $error("queue valid bits are not a prefix");

    // An expired alarm is never reported ahead of its deadline.
    a_expiry_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_EXPIRED)) |->
        (r_out_deadline <= r_now))
        else $error("alarm reported before its deadline");

    // A tick transfer advances the time by exactly one second.
    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_s_axis_tuser == MODE_TICK)) |=>
        (r_now == $past(r_now) + DL_W'(1)))
        else $error("tick did not advance the time");

    // An accepted insert grows the queue by exactly one alarm.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert |=> ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add exactly one alarm");

endmodule
